@@ src/pic_pkg.sv @@
package pic_pkg;

    localparam int MaxObjects = 32;
    localparam int FracBits   = 16;
    localparam int IdxW       = $clog2(MaxObjects);
    localparam int CntW       = $clog2(MaxObjects + 1);

    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_COLLIDE = 2'd2,
        CMD_READ    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    // saturate a signed 66-bit value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        begin
            hi = 66'sh7FFFFFFF;
            lo = -66'sh80000000;
            if (x > hi)      sat32 = 32'sh7FFFFFFF;
            else if (x < lo) sat32 = 32'sh80000000;
            else             sat32 = x[31:0];
        end
    endfunction

endpackage

@@ src/particle_integrator_with_collision.sv @@
// Particle table of up to 32 2D particles in signed Q16.16. One command is in
// flight at a time; o_in_stall is high while busy. A tick walks every live
// particle in turn (one shared multiplier and one read/write port per store);
// a collide runs the 81 steps of the bit-serial divider that produces one
// quotient bit per cycle, and skips the divider when the normal vanishes.
// A result that finds the output register still stalled waits in S_HOLD.
// A result waiting in the output register does not block the next command.
module particle_integrator_with_collision (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [4:0]  i_object_index,
    input  logic [30:0] i_delta,
    input  logic signed [31:0] i_normal_x,
    input  logic signed [31:0] i_normal_y,
    input  logic signed [31:0] i_contact_x,
    input  logic signed [31:0] i_contact_y,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [4:0]  o_result_index,
    output logic [5:0]  o_object_count,
    output logic signed [31:0] o_position_x,
    output logic signed [31:0] o_position_y,
    output logic signed [31:0] o_velocity_x,
    output logic signed [31:0] o_velocity_y
);

    localparam int IdxW = pic_pkg::IdxW;
    localparam int CntW = pic_pkg::CntW;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_RDW, S_T1, S_T2, S_T3, S_T4, S_T5, S_TW,
        S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_CDIV, S_C7, S_C8, S_C9, S_C10,
        S_CW, S_OUT, S_HOLD
    } t_state;

    t_state r_state;
    logic [CntW-1:0] r_live;
    logic signed [31:0] r_grav;
    logic [1:0]  r_cmd;
    logic [IdxW-1:0] r_idx;
    logic [4:0]  r_ridx;
    logic [30:0] r_delta;
    logic signed [31:0] r_nx, r_ny, r_cx, r_cy;
    logic signed [31:0] r_px, r_py, r_vx, r_vy;
    logic signed [65:0] r_acc, r_acc2, r_gd;
    logic signed [31:0] r_coeff;
    logic [1:0]  r_status;

    // shared multiplier
    logic signed [32:0] n_ma, n_mb;
    logic signed [65:0] w_p;
    pic_mul u_mul (.i_clk(i_clk), .i_a(n_ma), .i_b(n_mb), .o_p(w_p));

    // stores
    logic            n_we;
    logic [IdxW-1:0] n_addr;
    logic [31:0]     n_wpx, n_wpy, n_wvx, n_wvy;
    logic [31:0]     w_px, w_py, w_vx, w_vy;
    pic_ram #(.Width(32), .Depth(pic_pkg::MaxObjects)) u_px (.i_clk(i_clk), .i_we(n_we),
        .i_waddr(n_addr), .i_wdata(n_wpx), .i_raddr(n_addr), .o_rdata(w_px));
    pic_ram #(.Width(32), .Depth(pic_pkg::MaxObjects)) u_py (.i_clk(i_clk), .i_we(n_we),
        .i_waddr(n_addr), .i_wdata(n_wpy), .i_raddr(n_addr), .o_rdata(w_py));
    pic_ram #(.Width(32), .Depth(pic_pkg::MaxObjects)) u_vx (.i_clk(i_clk), .i_we(n_we),
        .i_waddr(n_addr), .i_wdata(n_wvx), .i_raddr(n_addr), .o_rdata(w_vx));
    pic_ram #(.Width(32), .Depth(pic_pkg::MaxObjects)) u_vy (.i_clk(i_clk), .i_we(n_we),
        .i_waddr(n_addr), .i_wdata(n_wvy), .i_raddr(n_addr), .o_rdata(w_vy));

    // divider
    logic        n_dstart;
    logic [64:0] n_dnum;
    logic        w_ddone;
    logic [31:0] w_dq;
    logic        r_neg;
    pic_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(n_dstart), .i_num(n_dnum),
        .i_den(r_acc2[64:0]), .o_done(w_ddone), .o_quot(w_dq));

    always_comb begin
        n_ma = '0;
        n_mb = '0;
        unique case (r_state)
            S_IDLE: begin n_ma = 33'(r_grav); n_mb = {2'b00, i_delta}; end
            S_T2:   begin n_ma = 33'(r_vx);   n_mb = {2'b00, r_delta}; end
            S_T3:   begin n_ma = 33'(r_vy);   n_mb = {2'b00, r_delta}; end
            S_C1:   begin n_ma = 33'(r_nx);   n_mb = 33'(r_vx); end
            S_C2:   begin n_ma = 33'(r_ny);   n_mb = 33'(r_vy); end
            S_C3:   begin n_ma = 33'(r_nx);   n_mb = 33'(r_nx); end
            S_C4:   begin n_ma = 33'(r_ny);   n_mb = 33'(r_ny); end
            S_C7:   begin n_ma = 33'(r_coeff); n_mb = 33'(r_nx); end
            S_C8:   begin n_ma = 33'(r_coeff); n_mb = 33'(r_ny); end
            default: ;
        endcase
    end

    always_comb begin
        n_dstart = (r_state == S_C6) && (r_acc2 > 0);
        n_dnum   = r_acc[65] ? 65'(-r_acc) : r_acc[64:0];
    end

    always_comb begin
        n_we  = 1'b0;
        n_addr = r_idx;
        n_wpx = r_px; n_wpy = r_py; n_wvx = r_vx; n_wvy = r_vy;
        if (r_state == S_IDLE && i_in_valid) n_addr = r_live[IdxW-1:0];
        if (r_state == S_IDLE && i_in_valid
            && pic_pkg::t_cmd'(i_command) == pic_pkg::CMD_CREATE
            && r_live < CntW'(pic_pkg::MaxObjects)) begin
            n_we = 1'b1;
            n_wpx = '0; n_wpy = '0; n_wvx = '0; n_wvy = '0;
        end
        if (r_state == S_T5) n_we = 1'b1;
        // collide snaps the stored position to the contact point
        if (r_state == S_C10) begin
            n_we  = 1'b1;
            n_wpx = r_cx;
            n_wpy = r_cy;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_live  <= '0;
            r_grav  <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall && r_state != S_HOLD) o_out_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) r_grav <= i_cfg_data;
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_cmd   <= i_command;
                    r_delta <= i_delta;
                    r_nx <= i_normal_x; r_ny <= i_normal_y;
                    r_cx <= i_contact_x; r_cy <= i_contact_y;
                    r_px <= '0; r_py <= '0; r_vx <= '0; r_vy <= '0;
                    unique case (pic_pkg::t_cmd'(i_command))
                        pic_pkg::CMD_CREATE: begin
                            r_idx <= i_object_index[IdxW-1:0];
                            if (r_live < CntW'(pic_pkg::MaxObjects)) begin
                                r_ridx   <= 5'(r_live);
                                r_live   <= r_live + 1'b1;
                                r_status <= pic_pkg::ST_OK;
                            end else begin
                                r_ridx   <= '0;
                                r_status <= pic_pkg::ST_FULL;
                            end
                            r_state <= S_OUT;
                        end
                        pic_pkg::CMD_TICK: begin
                            r_ridx   <= '0;
                            r_idx    <= '0;
                            r_status <= pic_pkg::ST_OK;
                            r_state  <= (r_live == '0) ? S_OUT : S_TW;
                        end
                        default: begin
                            r_idx  <= i_object_index[IdxW-1:0];
                            r_ridx <= i_object_index;
                            if (CntW'(i_object_index) >= r_live) begin
                                r_status <= pic_pkg::ST_BAD;
                                r_state  <= S_OUT;
                            end else begin
                                r_status <= pic_pkg::ST_OK;
                                r_state  <= S_RD;
                            end
                        end
                    endcase
                end
                S_TW: begin r_gd <= w_p; r_state <= S_T1; end
                S_T1: begin
                    r_px <= w_px; r_py <= w_py; r_vx <= w_vx;
                    r_vy <= pic_pkg::sat32(66'(signed'(w_vy)) + r_gd);
                    r_state <= S_T2;
                end
                S_T2: r_state <= S_T3;
                S_T3: begin r_acc <= w_p; r_state <= S_T4; end
                S_T4: begin
                    r_px <= pic_pkg::sat32(66'(r_px) + r_acc);
                    r_py <= pic_pkg::sat32(66'(r_py) + w_p);
                    r_state <= S_T5;
                end
                S_T5: begin
                    r_px <= '0; r_py <= '0; r_vx <= '0; r_vy <= '0;
                    if (CntW'(r_idx) + 1'b1 >= r_live) r_state <= S_OUT;
                    else begin r_idx <= r_idx + 1'b1; r_state <= S_RDW; end
                end
                S_RDW: r_state <= S_T1;
                S_RD: r_state <= S_CW;
                S_CW: begin
                    r_px <= w_px; r_py <= w_py; r_vx <= w_vx; r_vy <= w_vy;
                    r_state <= (pic_pkg::t_cmd'(r_cmd) == pic_pkg::CMD_COLLIDE) ? S_C1 : S_OUT;
                end
                S_C1: r_state <= S_C2;
                S_C2: begin r_acc <= w_p; r_state <= S_C3; end
                S_C3: begin r_acc <= r_acc + w_p; r_state <= S_C4; end
                S_C4: begin r_acc2 <= w_p; r_state <= S_C5; end
                S_C5: begin r_acc2 <= r_acc2 + w_p; r_state <= S_C6; end
                S_C6: begin
                    r_neg <= r_acc[65];
                    r_state <= (r_acc2 > 0) ? S_CDIV : S_C10;
                end
                S_CDIV: if (w_ddone) begin
                    // coeff is -(sign(dot) * q)
                    r_coeff <= r_neg ? pic_pkg::sat32(66'(w_dq))
                                     : pic_pkg::sat32(-66'(w_dq));
                    r_state <= S_C7;
                end
                S_C7: r_state <= S_C8;
                S_C8: begin
                    r_vx <= pic_pkg::sat32(66'(r_vx) + w_p);
                    r_state <= S_C9;
                end
                S_C9: begin
                    r_vy <= pic_pkg::sat32(66'(r_vy) + w_p);
                    r_state <= S_C10;
                end
                S_C10: begin
                    r_px <= r_cx; r_py <= r_cy;
                    r_state <= S_OUT;
                end
                S_OUT: r_state <= S_HOLD;
                S_HOLD: if (!o_out_valid || !i_out_stall) begin
                    o_out_valid    <= 1'b1;
                    o_status       <= r_status;
                    o_result_index <= r_ridx;
                    o_object_count <= 6'(r_live);
                    o_position_x   <= r_px;
                    o_position_y   <= r_py;
                    o_velocity_x   <= r_vx;
                    o_velocity_y   <= r_vy;
                    r_state        <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ src/pic_ram.sv @@
module pic_ram #(
    parameter int Width = 32,
    parameter int Depth = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ src/pic_mul.sv @@
// registered signed 33x33 multiplier with floor shift by the fraction width
module pic_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= (66'(i_a) * 66'(i_b)) >>> pic_pkg::FracBits;
    end

endmodule

@@ src/pic_div.sv @@
// restoring divider, one quotient bit a cycle: q = (a << F) / b, clamped
module pic_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [64:0] i_num,
    input  logic [64:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);

    localparam int Steps = 65 + pic_pkg::FracBits;
    localparam int CntW  = $clog2(Steps + 1);

    logic [Steps-1:0] r_num;
    logic [64:0]      r_rem;
    logic [64:0]      r_den;
    logic [41:0]      r_q;
    logic             r_big;
    logic [CntW-1:0]  r_cnt;
    logic             r_busy;
    logic [65:0]      n_rem;
    logic             n_ge;

    always_comb begin
        n_rem = {r_rem, r_num[Steps-1]};
        n_ge  = n_rem >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= {i_num, {pic_pkg::FracBits{1'b0}}};
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
                r_big  <= 1'b0;
                r_cnt  <= CntW'(Steps);
            end else if (r_busy) begin
                r_num <= r_num << 1;
                r_rem <= n_ge ? 65'(n_rem - {1'b0, r_den}) : n_rem[64:0];
                if (r_q[41:40] != 2'b00) r_big <= 1'b1;
                r_q   <= {r_q[40:0], n_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_big || r_q > 42'h80000000) o_quot = 32'h80000000;
        else                             o_quot = r_q[31:0];
    end

endmodule
